### src/dgr_pkg.sv
// Shared types, sizes and helper functions for the disc and glyph raster engine.
// No dependencies; every other file imports this package.
`default_nettype none

package dgr_pkg;

   localparam int MAX_WIDTH  = 512;
   localparam int MAX_HEIGHT = 512;

   localparam int CFG_W   = 10;
   localparam int DIM_W   = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);
   localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int TOT_W   = $clog2(DEPTH + 1);

   localparam int OP_W      = 2;
   localparam int POS_W     = 11;
   localparam int RAD_W     = 10;
   localparam int RGB_W     = 24;
   localparam int GLYPH_W   = 64;
   localparam int BIDX_W    = 17;
   localparam int BYTE_W    = 8;
   localparam int PIX_W     = 3;
   localparam int CSR_IDX_W = 2;

   // working widths of signed coordinates and of unsigned squared distances
   localparam int COORD_W = 13;
   localparam int SQ_W    = 24;

   // pixels that one packed byte can touch, and the pixel index width of a read
   localparam int FETCH_PIX = 4;
   localparam int FCNT_W    = $clog2(FETCH_PIX + 1);
   localparam int RPIX_W    = BIDX_W + 4;

   // ceil(2^BIDX_W / 3): (b * DIV3_RECIP) >> BIDX_W is b / 3 for any b below 2^BIDX_W
   localparam logic [BIDX_W-1:0] DIV3_RECIP = 17'd43691;

   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [CFG_W-1:0]     SIZE_RESET       = 10'd512;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

   localparam logic [PIX_W-1:0] COLOR_BLACK = 3'd0;
   localparam logic [PIX_W-1:0] COLOR_WHITE = 3'd7;
   localparam logic [7:0]       CHAN_HALF   = 8'h80;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR = 2'd0,
      OP_DISC  = 2'd1,
      OP_GLYPH = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic signed [POS_W-1:0]   pos_x;
      logic signed [POS_W-1:0]   pos_y;
      logic [RAD_W-1:0]          radius;
      logic [PIX_W-1:0]          color;
      logic [GLYPH_W-1:0]        glyph_rows;
      logic [BIDX_W-1:0]         byte_index;
   } cmd_type;

   typedef struct packed {
      logic [DIM_W-1:0] w;
      logic [DIM_W-1:0] h;
      logic [TOT_W-1:0] total;
      logic [TOT_W-1:0] plen;
   } geom_type;

   function automatic logic [DIM_W-1:0] eff_size(input logic [CFG_W-1:0] v, input int maxv);
      logic [DIM_W-1:0] res;
      if (v == '0) begin
         res = DIM_W'(1);
      end else if (32'(v) > maxv) begin
         res = DIM_W'(maxv);
      end else begin
         res = DIM_W'(v);
      end
      return res;
   endfunction

   // byte index = 3q + j: first pixel is 8q + pix_offset(j)
   function automatic logic [2:0] pix_offset(input logic [1:0] j);
      logic [2:0] res;
      unique case (j)
         2'd0:    res = 3'd0;
         2'd1:    res = 3'd2;
         2'd2:    res = 3'd5;
         default: res = 3'd0;
      endcase
      return res;
   endfunction

   // bit of the first pixel that lands in bit 0 of the byte
   function automatic logic [1:0] bit_offset(input logic [1:0] j);
      logic [1:0] res;
      unique case (j)
         2'd0:    res = 2'd0;
         2'd1:    res = 2'd2;
         2'd2:    res = 2'd1;
         default: res = 2'd0;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

### src/dgr_ifs.sv
// Channel interfaces of the raster engine: command, response and register write.
// Depends on dgr_pkg.
`default_nettype none

interface dgr_req_if import dgr_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic signed [POS_W-1:0]  pos_x;
   logic signed [POS_W-1:0]  pos_y;
   logic [RAD_W-1:0]         radius;
   logic [RGB_W-1:0]         fill_rgb;
   logic [GLYPH_W-1:0]       glyph_rows;
   logic [BIDX_W-1:0]        byte_index;

   modport source (output valid, op, pos_x, pos_y, radius, fill_rgb, glyph_rows, byte_index,
                   input ready);
   modport sink   (input valid, op, pos_x, pos_y, radius, fill_rgb, glyph_rows, byte_index,
                   output ready);
endinterface

interface dgr_rsp_if import dgr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] read_byte;
   logic              out_of_range;

   modport source (output valid, read_byte, out_of_range, input ready);
   modport sink   (input valid, read_byte, out_of_range, output ready);
endinterface

interface dgr_csr_if import dgr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/dgr_front.sv
// Front end: frame size registers, derived geometry, command decode.
// Depends on dgr_pkg and dgr_ifs.
`default_nettype none

module dgr_front import dgr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   dgr_req_if.sink     req_if,
   dgr_csr_if.sink     csr_if,
   output logic        push_valid,
   input  logic        push_ready,
   output cmd_type     push_cmd,
   output geom_type    geom
);

   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic [TOT_W-1:0] total_ff;
   logic [TOT_W-1:0] plen_ff;
   logic [DIM_W-1:0] w_eff, h_eff;
   logic [TOT_W+1:0] plen_sum;
   logic [PIX_W-1:0] disc_color;

   assign csr_if.ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            REG_FRAME_WIDTH:  width_in  = csr_if.data;
            REG_FRAME_HEIGHT: height_in = csr_if.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SIZE_RESET;
         height_ff <= SIZE_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign w_eff = eff_size(width_ff, MAX_WIDTH);
   assign h_eff = eff_size(height_ff, MAX_HEIGHT);

   // packed length (3*total+7)/8, one register after the product
   assign plen_sum = (TOT_W + 2)'(total_ff) * (TOT_W + 2)'(PIX_W) + (TOT_W + 2)'(7);

   always_ff @(posedge clock) begin
      total_ff <= TOT_W'(w_eff * h_eff);
      plen_ff  <= TOT_W'(plen_sum >> 3);
   end

   assign geom.w     = w_eff;
   assign geom.h     = h_eff;
   assign geom.total = total_ff;
   assign geom.plen  = plen_ff;

   // channel at least half scale sets its color bit
   assign disc_color = {req_if.fill_rgb[7:0]   >= CHAN_HALF,
                        req_if.fill_rgb[15:8]  >= CHAN_HALF,
                        req_if.fill_rgb[23:16] >= CHAN_HALF};

   always_comb begin
      push_cmd.op         = op_type'(req_if.op);
      push_cmd.pos_x      = req_if.pos_x;
      push_cmd.pos_y      = req_if.pos_y;
      push_cmd.radius     = req_if.radius;
      push_cmd.glyph_rows = req_if.glyph_rows;
      push_cmd.byte_index = req_if.byte_index;
      unique case (op_type'(req_if.op))
         OP_DISC:  push_cmd.color = disc_color;
         OP_GLYPH: push_cmd.color = COLOR_WHITE;
         OP_CLEAR: push_cmd.color = COLOR_BLACK;
         OP_READ:  push_cmd.color = COLOR_BLACK;
         default:  push_cmd.color = COLOR_BLACK;
      endcase
   end

   assign push_valid   = req_if.valid;
   assign req_if.ready = push_ready;

endmodule

`default_nettype wire

### src/dgr_cmd_queue.sv
// Short command queue between the decode front end and the drawing back end.
// Depends on dgr_pkg.
`default_nettype none

module dgr_cmd_queue import dgr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   cmd_type            slot_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               push, pop;

   assign push_ready = (count_ff != QCNT_W'(QDEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_cmd    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

### src/dgr_back.sv
// Back end: frame store, clear sweep, box walker for discs and glyphs,
// packed byte read, and the response register. Depends on dgr_pkg and dgr_ifs.
`default_nettype none

module dgr_back import dgr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     pop_valid,
   output logic     pop_ready,
   input  cmd_type  pop_cmd,
   input  geom_type geom,
   dgr_rsp_if.source rsp_if
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_SETUP  = 8'b0000_0010,
      ST_SQUARE = 8'b0000_0100,
      ST_WALK   = 8'b0000_1000,
      ST_CLEAR  = 8'b0001_0000,
      ST_DIV    = 8'b0010_0000,
      ST_FETCH  = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   cmd_type   cmd_ff;

   logic signed [COORD_W-1:0] x0_ff, x0_in, x1_ff, x1_in, y0_ff, y0_in, y1_ff, y1_in;
   logic signed [COORD_W-1:0] dx0_ff, dx0_in, dy0_ff, dy0_in;
   logic signed [COORD_W-1:0] x_ff, x_in, y_ff, y_in, dx_ff, dx_in, dy_ff, dy_in;
   logic [SQ_W-1:0]   dx2_ff, dx2_in, dy2_ff, dy2_in, dx0sq_ff, dx0sq_in, rr_ff, rr_in;
   logic [ADDR_W-1:0] base_ff, base_in, clr_addr_ff, clr_addr_in;
   logic [2:0]        gx_ff, gx_in, gy_ff, gy_in, gx0_ff, gx0_in;
   logic [BIDX_W-1:0] quo_ff, quo_in;
   logic [1:0]        rem_ff, rem_in;
   logic [FCNT_W-1:0] fcnt_ff, fcnt_in;
   logic [FETCH_PIX*PIX_W-1:0] bits_ff, bits_in;
   logic              oor_ff, oor_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_oor_ff, rsp_oor_in;
   logic              rsp_load;

   logic [PIX_W-1:0]  frame_mem [DEPTH];
   logic [PIX_W-1:0]  rdata_ff;
   logic              rvalid_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] waddr, raddr;
   logic [PIX_W-1:0]  wdata;
   logic [RPIX_W-1:0] rpix;

   logic signed [COORD_W-1:0] cx, cy, rad, lo_x, hi_x, lo_y, hi_y, wm1, hm1;
   logic signed [COORD_W-1:0] sx0, sx1, sy0, sy1;
   logic                      box_empty, read_oor;
   logic signed [2*COORD_W-1:0] dx0_sq_p, dy0_sq_p;
   logic [2*RAD_W-1:0]          rr_p;
   logic [COORD_W+DIM_W-1:0]    base_p;
   logic [SQ_W:0]               dist_sum;
   logic                        hit;
   logic [2*BIDX_W-1:0]         quo_p;
   logic [BIDX_W-1:0]           quo_w;

   assign cx  = COORD_W'(cmd_ff.pos_x);
   assign cy  = COORD_W'(cmd_ff.pos_y);
   assign rad = signed'(COORD_W'(cmd_ff.radius));
   assign wm1 = signed'(COORD_W'(geom.w)) - COORD_W'(1);
   assign hm1 = signed'(COORD_W'(geom.h)) - COORD_W'(1);

   // bounding box, clipped to the active frame
   always_comb begin
      if (cmd_ff.op == OP_GLYPH) begin
         lo_x = cx;
         hi_x = cx + COORD_W'(7);
         lo_y = cy;
         hi_y = cy + COORD_W'(7);
      end else begin
         lo_x = cx - rad;
         hi_x = cx + rad;
         lo_y = cy - rad;
         hi_y = cy + rad;
      end
      sx0 = (lo_x < 0) ? '0 : lo_x;
      sx1 = (hi_x > wm1) ? wm1 : hi_x;
      sy0 = (lo_y < 0) ? '0 : lo_y;
      sy1 = (hi_y > hm1) ? hm1 : hi_y;
   end

   assign box_empty = (sx0 > sx1) || (sy0 > sy1);
   assign read_oor  = (32'(cmd_ff.byte_index) >= 32'(geom.plen));

   assign dx0_sq_p = dx0_ff * dx0_ff;
   assign dy0_sq_p = dy0_ff * dy0_ff;
   assign rr_p     = cmd_ff.radius * cmd_ff.radius;
   assign base_p   = unsigned'(y0_ff) * geom.w;

   assign dist_sum = dx2_ff + dy2_ff;
   assign hit = (cmd_ff.op == OP_DISC) ? (dist_sum <= {1'b0, rr_ff})
                                       : cmd_ff.glyph_rows[{gy_ff, gx_ff}];

   // byte index over three by reciprocal multiply
   assign quo_p = (2*BIDX_W)'(cmd_ff.byte_index) * (2*BIDX_W)'(DIV3_RECIP);
   assign quo_w = quo_p[2*BIDX_W-1:BIDX_W];

   assign rpix = RPIX_W'({quo_ff, 3'b000}) + RPIX_W'(pix_offset(rem_ff)) + RPIX_W'(fcnt_ff);

   assign pop_ready = (state_ff == ST_IDLE);
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_if.ready);

   always_comb begin
      state_in    = state_ff;
      x0_in       = x0_ff;
      x1_in       = x1_ff;
      y0_in       = y0_ff;
      y1_in       = y1_ff;
      dx0_in      = dx0_ff;
      dy0_in      = dy0_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      dx2_in      = dx2_ff;
      dy2_in      = dy2_ff;
      dx0sq_in    = dx0sq_ff;
      rr_in       = rr_ff;
      base_in     = base_ff;
      clr_addr_in = clr_addr_ff;
      gx_in       = gx_ff;
      gy_in       = gy_ff;
      gx0_in      = gx0_ff;
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      fcnt_in     = fcnt_ff;
      bits_in     = bits_ff;
      oor_in      = oor_ff;
      mem_we      = 1'b0;
      waddr       = base_ff + ADDR_W'(unsigned'(x_ff));
      wdata       = cmd_ff.color;

      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            x0_in  = sx0;
            x1_in  = sx1;
            y0_in  = sy0;
            y1_in  = sy1;
            dx0_in = sx0 - cx;
            dy0_in = sy0 - cy;
            gx0_in = 3'(sx0 - cx);
            gy_in  = 3'(sy0 - cy);
            oor_in = 1'b0;
            unique case (cmd_ff.op)
               OP_CLEAR: begin
                  clr_addr_in = '0;
                  state_in    = ST_CLEAR;
               end
               OP_DISC, OP_GLYPH: begin
                  state_in = box_empty ? ST_DONE : ST_SQUARE;
               end
               OP_READ: begin
                  oor_in   = read_oor;
                  state_in = read_oor ? ST_DONE : ST_DIV;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_SQUARE: begin
            dx0sq_in = SQ_W'(unsigned'(dx0_sq_p));
            dx2_in   = SQ_W'(unsigned'(dx0_sq_p));
            dy2_in   = SQ_W'(unsigned'(dy0_sq_p));
            rr_in    = SQ_W'(rr_p);
            base_in  = ADDR_W'(base_p);
            x_in     = x0_ff;
            y_in     = y0_ff;
            dx_in    = dx0_ff;
            dy_in    = dy0_ff;
            gx_in    = gx0_ff;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            mem_we = hit;
            if (x_ff == x1_ff) begin
               if (y_ff == y1_ff) begin
                  state_in = ST_DONE;
               end else begin
                  // next row: (dy+1)^2 = dy^2 + 2dy + 1
                  y_in    = y_ff + COORD_W'(1);
                  dy_in   = dy_ff + COORD_W'(1);
                  dy2_in  = SQ_W'(signed'({1'b0, dy2_ff})
                                  + ((SQ_W + 1)'(dy_ff) <<< 1) + (SQ_W + 1)'(1));
                  base_in = base_ff + ADDR_W'(geom.w);
                  x_in    = x0_ff;
                  dx_in   = dx0_ff;
                  dx2_in  = dx0sq_ff;
                  gx_in   = gx0_ff;
                  gy_in   = gy_ff + 3'd1;
               end
            end else begin
               x_in   = x_ff + COORD_W'(1);
               dx_in  = dx_ff + COORD_W'(1);
               dx2_in = SQ_W'(signed'({1'b0, dx2_ff})
                              + ((SQ_W + 1)'(dx_ff) <<< 1) + (SQ_W + 1)'(1));
               gx_in  = gx_ff + 3'd1;
            end
         end
         ST_CLEAR: begin
            mem_we = 1'b1;
            waddr  = clr_addr_ff;
            wdata  = COLOR_BLACK;
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_DONE;
            end else begin
               clr_addr_in = clr_addr_ff + ADDR_W'(1);
            end
         end
         ST_DIV: begin
            // split the byte index into 3q + j
            quo_in   = quo_w;
            rem_in   = 2'(cmd_ff.byte_index - (quo_w + (quo_w << 1)));
            fcnt_in  = '0;
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            fcnt_in = fcnt_ff + FCNT_W'(1);
            if (fcnt_ff != '0) begin
               bits_in = {(rvalid_ff ? rdata_ff : COLOR_BLACK),
                          bits_ff[FETCH_PIX*PIX_W-1:PIX_W]};
            end
            if (fcnt_ff == FCNT_W'(FETCH_PIX)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && pop_valid) begin
         cmd_ff <= pop_cmd;
      end
      x0_ff       <= x0_in;
      x1_ff       <= x1_in;
      y0_ff       <= y0_in;
      y1_ff       <= y1_in;
      dx0_ff      <= dx0_in;
      dy0_ff      <= dy0_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      dx2_ff      <= dx2_in;
      dy2_ff      <= dy2_in;
      dx0sq_ff    <= dx0sq_in;
      rr_ff       <= rr_in;
      base_ff     <= base_in;
      clr_addr_ff <= clr_addr_in;
      gx_ff       <= gx_in;
      gy_ff       <= gy_in;
      gx0_ff      <= gx0_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      fcnt_ff     <= fcnt_in;
      bits_ff     <= bits_in;
      oor_ff      <= oor_in;
   end

   // frame store: one write and one registered read per cycle
   assign raddr = ADDR_W'(rpix);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[waddr] <= wdata;
      end
      rdata_ff  <= frame_mem[raddr];
      rvalid_ff <= (32'(rpix) < 32'(geom.total));
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_oor_in   = rsp_oor_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_oor_in   = oor_ff;
         rsp_byte_in  = (cmd_ff.op == OP_READ && !oor_ff)
                        ? BYTE_W'(bits_ff >> bit_offset(rem_ff)) : '0;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_byte_ff <= rsp_byte_in;
      rsp_oor_ff  <= rsp_oor_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.read_byte    = rsp_byte_ff;
   assign rsp_if.out_of_range = rsp_oor_ff;

`ifndef SYNTHESIS
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_WALK || state_ff == ST_CLEAR))
      else $error("frame store written outside walk or clear");

   a_walk_in_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && mem_we) |-> (x_ff >= 0 && x_ff <= wm1 && y_ff >= 0 && y_ff <= hm1))
      else $error("drawn pixel outside active frame");

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (state_ff == ST_IDLE && rsp_valid_ff))
      else $error("response load did not return to idle with a valid response");

   a_pop_setup: assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready) |=> (state_ff == ST_SETUP))
      else $error("popped command did not enter setup");
`endif

endmodule

`default_nettype wire

### src/disc_glyph_raster_engine.sv
// Top level of the disc and glyph raster engine: front end, command queue, back end.
// Depends on dgr_pkg, dgr_ifs, dgr_front, dgr_cmd_queue and dgr_back.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+-----------------------------------------------
//   req_if   | in  | valid/ready   | op, pos_x, pos_y, radius, fill_rgb, glyph_rows,
//            |     |               | byte_index
//   rsp_if   | out | valid/ready   | read_byte, out_of_range (one per command)
//   csr_if   | in  | valid/ready   | index (0 frame_width, 1 frame_height), data
//
// Work per command, set by the back end's single frame store write port:
//   clear: writes all MAX_WIDTH*MAX_HEIGHT entries, one entry per cycle.
//   disc/glyph: walks the clipped bounding box, one pixel per cycle.
//   read: a divide step (reciprocal multiply), then a fetch of up to four pixels.
// Reset is synchronous, active high; the frame store is undefined until a clear.
// The queue holds two commands, so the front end can take up to two items while the back
// end draws or while a finished response waits in the output register.
`default_nettype none

module disc_glyph_raster_engine import dgr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   dgr_req_if.sink   req_if,
   dgr_rsp_if.source rsp_if,
   dgr_csr_if.sink   csr_if
);

   logic     push_valid, push_ready;
   logic     pop_valid, pop_ready;
   cmd_type  push_cmd, pop_cmd;
   geom_type geom;

   // decode commands and hold the frame size registers
   dgr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .csr_if     (csr_if),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .geom       (geom)
   );

   // decouple decode from drawing
   dgr_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // draw into and read from the frame store, drive responses
   dgr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .geom      (geom),
      .rsp_if    (rsp_if)
   );

endmodule

`default_nettype wire
